### design/lebdmx_pkg.sv
// Package for the LEB128 length-prefixed two-stream demux parser.
// Holds the payload structs, queue sizes and header constants.
// No dependencies.
package lebdmx_pkg;

  // Header limits and field widths.
  localparam int MAX_HEADER_BYTES = 10;
  localparam int HDR_IDX_W        = 4;
  localparam int LEN_W            = 64;
  localparam int SHIFT_W          = 8;
  localparam logic [HDR_IDX_W-1:0] HDR_IDX_LAST = HDR_IDX_W'(MAX_HEADER_BYTES - 1);

  // Byte masks.
  localparam logic [7:0] DATA_MASK = 8'h7f;
  localparam logic [7:0] CONT_MASK = 8'h80;

  // Queue between the parser and the output stage.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  // Configuration port.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-1:0] REG_MODE_ADDR = CFG_ADDR_W'(0);

  // One input item.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_in_chunk;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       stream_id;
    logic       format_error;
  } out_item_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

### design/leb128_two_stream_demux_parser.sv
// Top level of the LEB128 two-stream demux parser: config register and glue.
// Depends on lebdmx_pkg, lebdmx_front, lebdmx_queue and lebdmx_back.
//
//   Channel  Direction  Handshake           Payload
//   in_      input      in_valid/in_ready   in_data  (in_byte, last_in_chunk)
//   out_     output     out_valid/out_ready out_data (out_byte, stream_id, format_error)
//   cfg_     APB slave  psel/penable/pready paddr, pwdata, prdata
//
// One byte is accepted per cycle while the queue has room; the parser state is registered.
// A result passes through the queue into the output register; output stalls hold it in the queue.
// Reset is synchronous; no clearing pass is needed after it.
// A stalled output fills the two-entry queue, after which in_ready drops.
module leb128_two_stream_demux_parser (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  lebdmx_pkg::in_item_t                in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output lebdmx_pkg::out_item_t               out_data,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lebdmx_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [lebdmx_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [lebdmx_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                                pready
);
  import lebdmx_pkg::*;

  logic      mode_r;
  logic      cfg_wr;
  logic      push;
  out_item_t push_data;
  logic      pop;
  out_item_t pop_data;
  q_status_t q_status;

  // Configuration register.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else if (cfg_wr && (paddr == REG_MODE_ADDR)) begin
      mode_r <= pwdata[0];
    end
  end

  assign prdata = (paddr == REG_MODE_ADDR) ? CFG_DATA_W'(mode_r) : '0;

  lebdmx_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .passthrough_mode (mode_r),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data          (in_data),
    .q_status         (q_status),
    .push             (push),
    .push_data        (push_data)
  );

  lebdmx_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_status  (q_status)
  );

  lebdmx_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_status  (q_status),
    .pop_data  (pop_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### design/lebdmx_front.sv
// Front end: accepts input bytes, tracks header and payload state.
// Pushes result items into the queue. Depends on lebdmx_pkg.
module lebdmx_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 passthrough_mode,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  lebdmx_pkg::in_item_t in_data,
  input  lebdmx_pkg::q_status_t q_status,
  output logic                 push,
  output lebdmx_pkg::out_item_t push_data
);
  import lebdmx_pkg::*;

  logic [HDR_IDX_W-1:0] hdr_idx_r, hdr_idx_nxt;
  logic [LEN_W-1:0]     rem_len_r, rem_len_nxt;
  logic                 in_payload_r, in_payload_nxt;
  logic                 cur_stream_r, cur_stream_nxt;

  logic                 accept;
  logic [HDR_IDX_W-1:0] idx;
  logic [SHIFT_W-1:0]   shift;
  logic [LEN_W-1:0]     bits;
  logic [LEN_W-1:0]     acc;
  logic [LEN_W-1:0]     rem_dec;

  // A new byte is taken whenever the queue has room.
  assign in_ready = !q_status.full;
  assign accept   = in_valid && in_ready;

  // Header position, clamped to the last allowed byte.
  assign idx   = (hdr_idx_r > HDR_IDX_LAST) ? HDR_IDX_LAST : hdr_idx_r;
  assign shift = SHIFT_W'(idx) * SHIFT_W'(7);
  assign bits  = LEN_W'(in_data.in_byte & DATA_MASK);
  assign rem_dec = rem_len_r - LEN_W'(1);

  // Accumulator with this byte's seven bits merged in.
  always_comb begin
    if (idx == '0) begin
      acc = bits;
    end else if (shift < SHIFT_W'(LEN_W)) begin
      acc = rem_len_r | (bits << shift);
    end else begin
      acc = rem_len_r;
    end
  end

  // Next state and the result of the accepted byte.
  always_comb begin
    hdr_idx_nxt    = hdr_idx_r;
    rem_len_nxt    = rem_len_r;
    in_payload_nxt = in_payload_r;
    cur_stream_nxt = cur_stream_r;
    push           = 1'b0;
    push_data      = '0;
    if (accept) begin
      if (passthrough_mode) begin
        push               = 1'b1;
        push_data.out_byte = in_data.in_byte;
      end else if (in_payload_r) begin
        push                = 1'b1;
        push_data.out_byte  = in_data.in_byte;
        push_data.stream_id = cur_stream_r;
        rem_len_nxt         = rem_dec;
        if (rem_dec == '0) begin
          in_payload_nxt = 1'b0;
        end
      end else begin
        rem_len_nxt = acc;
        if ((in_data.in_byte & CONT_MASK) != 8'h00) begin
          if (idx >= HDR_IDX_LAST) begin
            hdr_idx_nxt            = idx;
            push                   = 1'b1;
            push_data.format_error = 1'b1;
          end else begin
            hdr_idx_nxt = idx + HDR_IDX_W'(1);
          end
        end else begin
          // Header complete: bit 0 picks the stream, the rest is the length.
          cur_stream_nxt = acc[0];
          rem_len_nxt    = acc >> 1;
          hdr_idx_nxt    = '0;
          in_payload_nxt = (acc[LEN_W-1:1] != '0);
        end
      end
    end
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_idx_r    <= '0;
      rem_len_r    <= '0;
      in_payload_r <= 1'b0;
      cur_stream_r <= 1'b0;
    end else begin
      hdr_idx_r    <= hdr_idx_nxt;
      rem_len_r    <= rem_len_nxt;
      in_payload_r <= in_payload_nxt;
      cur_stream_r <= cur_stream_nxt;
    end
  end

endmodule

### design/lebdmx_queue.sv
// Short queue of result items between the parser and the output stage.
// Depends on lebdmx_pkg.
module lebdmx_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  lebdmx_pkg::out_item_t push_data,
  input  logic                  pop,
  output lebdmx_pkg::out_item_t pop_data,
  output lebdmx_pkg::q_status_t q_status
);
  import lebdmx_pkg::*;

  out_item_t         mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push;
  logic              do_pop;

  assign q_status.full  = (count_r == QCNT_W'(QDEPTH));
  assign q_status.empty = (count_r == '0);
  assign do_push  = push && !q_status.full;
  assign do_pop   = pop && !q_status.empty;
  assign pop_data = mem[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  // Storage write.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

### design/lebdmx_back.sv
// Back end: output register that drains the queue onto the result channel.
// Depends on lebdmx_pkg.
module lebdmx_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lebdmx_pkg::q_status_t q_status,
  input  lebdmx_pkg::out_item_t pop_data,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output lebdmx_pkg::out_item_t out_data
);
  import lebdmx_pkg::*;

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r;

  // Load a new item when the register is empty or its transfer completes.
  assign pop = !q_status.empty && (!out_valid_r || out_ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Payload register, no reset needed.
  always_ff @(posedge clk) begin
    if (pop) begin
      out_data_r <= pop_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### test/leb128_two_stream_demux_parser_tb.sv
// Testbench for the LEB128 length-prefixed two-stream demux parser.
// Runs directed and random byte streams against a built-in model of the parser.
// Depends on lebdmx_pkg and leb128_two_stream_demux_parser.
module leb128_two_stream_demux_parser_tb;
  import lebdmx_pkg::*;

  localparam int unsigned TOTAL_ITEMS  = 490;
  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned HOLD_CYCLES  = 80;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_data;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  // Model state: configuration and framing state of the parser.
  bit                    passthrough_q;
  logic [HDR_IDX_W-1:0]  hdr_idx;
  logic [LEN_W-1:0]      frame_len;
  bit                    payload_active;
  bit                    frame_stream;

  out_item_t             expected_outputs[$];
  out_item_t             oldest;
  int unsigned           error_count;
  int unsigned           items_sent;
  int unsigned           cycle_count;
  bit                    no_idle;
  bit                    hold_off_req;
  int unsigned           ready_len;

  leb128_two_stream_demux_parser i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Clock with a period of 10.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("ERROR at %0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    error_count++;
  endtask

  // Gap length: mostly none, sometimes a few cycles, rarely a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Parser model: updates the framing state for one byte and returns 1 when
  // the byte yields a result.
  function automatic bit predict_demux_byte(logic [7:0] b, output out_item_t res);
    logic [HDR_IDX_W-1:0] idx;
    logic [LEN_W-1:0]     group;
    int unsigned          shift;
    res = '0;
    if (passthrough_q) begin
      res.out_byte = b;
      return 1'b1;
    end
    if (payload_active) begin
      res.out_byte  = b;
      res.stream_id = frame_stream;
      frame_len     = frame_len - 1;
      if (frame_len == 0) payload_active = 1'b0;
      return 1'b1;
    end
    // Header byte: the index saturates at the last header position.
    idx = hdr_idx;
    if (idx > HDR_IDX_LAST) idx = HDR_IDX_LAST;
    group = LEN_W'(b & DATA_MASK);
    shift = 7 * idx;
    if (idx == 0) begin
      frame_len = group;
    end else if (shift < LEN_W) begin
      frame_len = frame_len | (group << shift);
    end
    if ((b & CONT_MASK) != 0) begin
      if (idx >= HDR_IDX_LAST) begin
        hdr_idx = idx;
        res.format_error = 1'b1;
        return 1'b1;
      end
      hdr_idx = idx + HDR_IDX_W'(1);
      return 1'b0;
    end
    // Header complete: bit 0 selects the stream, the rest is the length.
    frame_stream   = frame_len[0];
    frame_len      = frame_len >> 1;
    hdr_idx        = '0;
    payload_active = (frame_len != 0);
    return 1'b0;
  endfunction

  // Result checker: each transfer is compared with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_outputs.size() == 0) begin
        report_mismatch("result with nothing expected", 64'(out_data), 64'd0);
      end else begin
        oldest = expected_outputs.pop_front();
        if (out_data.out_byte !== oldest.out_byte)
          report_mismatch("out_byte", 64'(out_data.out_byte), 64'(oldest.out_byte));
        if (out_data.stream_id !== oldest.stream_id)
          report_mismatch("stream_id", 64'(out_data.stream_id), 64'(oldest.stream_id));
        if (out_data.format_error !== oldest.format_error)
          report_mismatch("format_error", 64'(out_data.format_error),
                          64'(oldest.format_error));
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off when requested.
  initial begin
    out_ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        ready_len    = HOLD_CYCLES;
        hold_off_req = 1'b0;
      end else begin
        ready_len = no_idle ? 0 : pick_gap();
      end
      out_ready <= (ready_len == 0);
      if (ready_len > 1) repeat (ready_len - 1) @(posedge clk);
    end
  end

  // Sends one byte, predicts its result on the transfer and idles at random.
  task automatic send_byte(logic [7:0] b, logic last);
    out_item_t   res;
    int unsigned gap;
    in_valid <= 1'b1;
    in_data  <= {b, last};
    do @(posedge clk); while (!in_ready);
    if (predict_demux_byte(b, res)) expected_outputs.push_back(res);
    items_sent++;
    gap = no_idle ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Lets every outstanding result drain so that the block is idle.
  task automatic drain_pipe();
    in_valid <= 1'b0;
    while (expected_outputs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic check_mode_reg();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= REG_MODE_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== CFG_DATA_W'(passthrough_q))
      report_mismatch("passthrough_mode readback", 64'(prdata), 64'(passthrough_q));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Writes the mode register once the block is idle, then reads it back.
  task automatic set_mode(bit passthrough);
    drain_pipe();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_MODE_ADDR;
    pwdata  <= CFG_DATA_W'(passthrough);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    passthrough_q = passthrough;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    check_mode_reg();
  endtask

  // Sends a header for (len, stream) padded with empty groups, then the
  // payload; only the first max_bytes bytes of the frame go out.
  task automatic send_frame(bit sid, int unsigned len, int unsigned pad,
                            int unsigned max_bytes);
    logic [LEN_W-1:0] hdr_val;
    int unsigned      groups;
    int unsigned      hdr_bytes;
    int unsigned      sent;
    logic [7:0]       b;
    hdr_val = (LEN_W'(len) << 1) | LEN_W'(sid);
    groups  = 1;
    while (groups < MAX_HEADER_BYTES && (hdr_val >> (7 * groups)) != 0) groups++;
    hdr_bytes = groups + pad;
    if (hdr_bytes > MAX_HEADER_BYTES) hdr_bytes = MAX_HEADER_BYTES;
    sent = 0;
    for (int unsigned i = 0; i < hdr_bytes && sent < max_bytes; i++) begin
      b = 8'(hdr_val >> (7 * i)) & DATA_MASK;
      if (i < hdr_bytes - 1) b = b | CONT_MASK;
      send_byte(b, 1'($urandom));
      sent++;
    end
    for (int unsigned i = 0; i < len && sent < max_bytes; i++) begin
      send_byte(8'($urandom), 1'($urandom));
      sent++;
    end
  endtask

  // Finishes any header or payload left open so a new frame starts cleanly.
  task automatic resync_framing();
    if (!payload_active && hdr_idx != 0) send_byte(8'h00, 1'b0);
    while (payload_active) send_byte(8'($urandom), 1'($urandom));
  endtask

  // Ten-byte header with a continuation bit on the last position, repeated
  // a few times; the overflowing groups keep bit 0 clear so the length stays
  // within what the first byte gives.
  task automatic send_overlong_header();
    int unsigned extra;
    send_byte(CONT_MASK | (8'($urandom) & DATA_MASK), 1'($urandom));
    repeat (MAX_HEADER_BYTES - 2) send_byte(CONT_MASK, 1'($urandom));
    extra = $urandom_range(1, 3);
    repeat (extra) send_byte(CONT_MASK | (8'($urandom) & 8'h7e), 1'($urandom));
    send_byte(8'($urandom) & 8'h7e, 1'($urandom));
  endtask

  function automatic int unsigned pick_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return 0;
    if (r < 85) return $urandom_range(1, 6);
    return $urandom_range(7, 40);
  endfunction

  function automatic int unsigned pick_pad();
    return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
  endfunction

  task automatic test_reset_value();
    check_mode_reg();
  endtask

  // Extreme byte values pass unchanged on stream 0.
  task automatic test_passthrough();
    set_mode(1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b1);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7f, 1'b1);
  endtask

  // One-byte frames on both streams.
  task automatic test_short_frames();
    set_mode(1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'haa, 1'b1);
    send_byte(8'h02, 1'b0);
    send_byte(8'h55, 1'b1);
  endtask

  // Zero-length frames give no payload on either stream.
  task automatic test_zero_length();
    send_byte(8'h00, 1'b0);
    send_byte(8'h01, 1'b1);
  endtask

  // Header running past ten bytes: errors, dropped high bits, then a frame.
  task automatic test_long_header();
    send_byte(8'h85, 1'b0);
    repeat (MAX_HEADER_BYTES - 2) send_byte(CONT_MASK, 1'b0);
    send_byte(8'h80, 1'b1);
    send_byte(8'hfe, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h3c, 1'b0);
    send_byte(8'hc3, 1'b1);
  endtask

  // Receiver stalls for a long stretch while a frame keeps coming in.
  task automatic test_backpressure();
    set_mode(1'b0);
    no_idle      = 1'b1;
    hold_off_req = 1'b1;
    send_frame(1'b1, 12, 0, 1000);
    no_idle = 1'b0;
  endtask

  // Random phases of passthrough and framed traffic with mode changes.
  task automatic test_random_traffic();
    bit          mode;
    int unsigned budget;
    int unsigned pick;
    while (items_sent < TOTAL_ITEMS) begin
      mode = ($urandom_range(0, 3) == 0);
      set_mode(mode);
      no_idle = ($urandom_range(0, 4) == 0);
      budget  = items_sent + $urandom_range(15, 60);
      if (mode) begin
        while (items_sent < budget) send_byte(8'($urandom), 1'($urandom));
      end else begin
        while (items_sent < budget) begin
          resync_framing();
          pick = $urandom_range(0, 99);
          if (pick < 8) begin
            send_overlong_header();
          end else if (pick < 16) begin
            send_frame(1'($urandom), pick_len(), pick_pad(), $urandom_range(1, 4));
          end else begin
            send_frame(1'($urandom), pick_len(), pick_pad(), 1000);
          end
        end
        // Sometimes leave a frame open across the next mode change.
        if ($urandom_range(0, 1) == 1) begin
          resync_framing();
          send_frame(1'($urandom), $urandom_range(2, 8), pick_pad(), $urandom_range(1, 5));
        end
      end
    end
    no_idle = 1'b0;
  endtask

  // Largest possible header value: all ones, a length that never runs out.
  task automatic test_huge_length();
    set_mode(1'b0);
    resync_framing();
    repeat (MAX_HEADER_BYTES - 1) send_byte(8'hff, 1'b0);
    send_byte(8'h01, 1'b1);
    repeat (20) send_byte(8'($urandom), 1'($urandom));
  endtask

  initial begin
    passthrough_q  = 1'b0;
    hdr_idx        = '0;
    frame_len      = '0;
    payload_active = 1'b0;
    frame_stream   = 1'b0;
    error_count    = 0;
    items_sent     = 0;
    no_idle        = 1'b0;
    hold_off_req   = 1'b0;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_data        <= '0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_value();
    test_passthrough();
    test_short_frames();
    test_zero_length();
    test_long_header();
    test_backpressure();
    test_random_traffic();
    test_huge_length();

    drain_pipe();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
